/* rtl/core/rop_pkg.sv */
// Shared types, operation codes and colour packing for the raster-op pixel unit.
package rop_pkg;

   localparam int PIXEL_W    = 32;
   localparam int COLOR_W    = 24;
   localparam int OP_W       = 5;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_BLACKNESS   = 5'd0,
      OP_WHITENESS   = 5'd1,
      OP_SRCCOPY     = 5'd2,
      OP_SPNA        = 5'd3,
      OP_DSNA        = 5'd4,
      OP_DSPDXAX     = 5'd5,
      OP_NOTSRCCOPY  = 5'd6,
      OP_DSTINVERT   = 5'd7,
      OP_SRCERASE    = 5'd8,
      OP_NOTSRCERASE = 5'd9,
      OP_SRCINVERT   = 5'd10,
      OP_SRCAND      = 5'd11,
      OP_SRCPAINT    = 5'd12,
      OP_MERGECOPY   = 5'd13,
      OP_MERGEPAINT  = 5'd14,
      OP_PATCOPY     = 5'd15,
      OP_PATINVERT   = 5'd16,
      OP_PATPAINT    = 5'd17,
      OP_PDXN        = 5'd18
   } op_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_INVERT_ORDER = 3'd0,
      REG_ALPHA_BLACK  = 3'd1,
      REG_BRUSH_SOLID  = 3'd2,
      REG_BRUSH_COLOR  = 3'd3,
      REG_TEXT_COLOR   = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic               invert_order;
      logic               alpha_black;
      logic               brush_solid;
      logic [COLOR_W-1:0] brush_color;
      logic [COLOR_W-1:0] text_color;
   } cfg_type;

   // Converts a 0x00BBGGRR colour into an opaque ARGB or ABGR word.
   function automatic logic [PIXEL_W-1:0] pack_color(input logic [COLOR_W-1:0] bgr,
                                                     input logic invert);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = bgr[7:0];
      g = bgr[15:8];
      b = bgr[23:16];
      if (invert) begin
         return {OPAQUE_ALPHA, b, g, r};
      end
      return {OPAQUE_ALPHA, r, g, b};
   endfunction

endpackage

/* rtl/core/rop_csr.sv */
// Configuration register file of the raster-op pixel unit.
module rop_csr import rop_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_INVERT_ORDER: cfg_in.invert_order = csr_pwdata[0];
            REG_ALPHA_BLACK:  cfg_in.alpha_black  = csr_pwdata[0];
            REG_BRUSH_SOLID:  cfg_in.brush_solid  = csr_pwdata[0];
            REG_BRUSH_COLOR:  cfg_in.brush_color  = csr_pwdata[COLOR_W-1:0];
            REG_TEXT_COLOR:   cfg_in.text_color   = csr_pwdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_INVERT_ORDER: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.invert_order};
         REG_ALPHA_BLACK:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.alpha_black};
         REG_BRUSH_SOLID:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.brush_solid};
         REG_BRUSH_COLOR:  csr_prdata = {{(CSR_DATA_W-COLOR_W){1'b0}}, cfg_ff.brush_color};
         REG_TEXT_COLOR:   csr_prdata = {{(CSR_DATA_W-COLOR_W){1'b0}}, cfg_ff.text_color};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert_order <= 1'b0;
         cfg_ff.alpha_black  <= 1'b0;
         cfg_ff.brush_solid  <= 1'b1;
         cfg_ff.brush_color  <= '0;
         cfg_ff.text_color   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/rop_alu.sv */
// Bitwise raster-operation datapath for one pixel.
module rop_alu import rop_pkg::*; (
   input  cfg_type              cfg,
   input  logic [OP_W-1:0]      op,
   input  logic [PIXEL_W-1:0]   src_pixel,
   input  logic [PIXEL_W-1:0]   dst_pixel,
   input  logic [PIXEL_W-1:0]   pat_pixel,
   output logic [PIXEL_W-1:0]   new_pixel,
   output logic                 bad_op
);

   logic [PIXEL_W-1:0] brush;
   logic [PIXEL_W-1:0] text;
   logic [COLOR_W-1:0] mask;
   logic [COLOR_W-1:0] glyph;

   // A solid brush replaces the pattern only for the pattern-copy and pattern-invert codes.
   assign brush = cfg.brush_solid ? pack_color(cfg.brush_color, cfg.invert_order)
                                  : pat_pixel;
   assign text  = pack_color(cfg.text_color, cfg.invert_order);
   assign mask  = {3{src_pixel[7:0]}};
   assign glyph = (mask & text[COLOR_W-1:0]) | (~mask & dst_pixel[COLOR_W-1:0]);

   always_comb begin
      bad_op = 1'b0;
      case (op_type'(op))
         OP_BLACKNESS:   new_pixel = cfg.alpha_black ? {OPAQUE_ALPHA, 24'h000000} : '0;
         OP_WHITENESS:   new_pixel = '1;
         OP_SRCCOPY:     new_pixel = src_pixel;
         OP_SPNA:        new_pixel = src_pixel & ~pat_pixel;
         OP_DSNA:        new_pixel = ~src_pixel & dst_pixel;
         OP_DSPDXAX:     new_pixel = {dst_pixel[PIXEL_W-1:COLOR_W], glyph};
         OP_NOTSRCCOPY:  new_pixel = ~src_pixel;
         OP_DSTINVERT:   new_pixel = ~dst_pixel;
         OP_SRCERASE:    new_pixel = src_pixel & ~dst_pixel;
         OP_NOTSRCERASE: new_pixel = ~src_pixel & ~dst_pixel;
         OP_SRCINVERT:   new_pixel = dst_pixel ^ src_pixel;
         OP_SRCAND:      new_pixel = dst_pixel & src_pixel;
         OP_SRCPAINT:    new_pixel = dst_pixel | src_pixel;
         OP_MERGECOPY:   new_pixel = src_pixel & pat_pixel;
         OP_MERGEPAINT:  new_pixel = ~src_pixel | dst_pixel;
         OP_PATCOPY:     new_pixel = brush;
         OP_PATINVERT:   new_pixel = dst_pixel ^ brush;
         OP_PATPAINT:    new_pixel = dst_pixel | pat_pixel | ~src_pixel;
         OP_PDXN:        new_pixel = dst_pixel ^ ~pat_pixel;
         default: begin
            new_pixel = dst_pixel;
            bad_op    = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/core/raster_op_pixel_unit.sv */
// Top level of the raster-op pixel unit: input register, datapath, result register.
// Each word on the request channel carries an operation code with source, destination
// and pattern pixels and yields one result word with the new destination pixel and an
// unknown-code flag. A word passes through two registers, the input register, which
// loads at the accepting edge, and the result register, which loads from it when it is
// empty or its word leaves; with the result side ready the unit takes and returns one
// word every cycle. The input register can still load while a result stalls, so a
// stalled result holds the pipeline only while both stages are full.
// Configuration registers should be written only while no word is in flight.
module raster_op_pixel_unit import rop_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [PIXEL_W-1:0]    req_src_pixel,
   input  logic [PIXEL_W-1:0]    req_dst_pixel,
   input  logic [PIXEL_W-1:0]    req_pat_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_W-1:0]    rsp_new_pixel,
   output logic                  rsp_bad_op,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type            cfg;
   logic               in_valid_ff;
   logic [OP_W-1:0]    in_op_ff;
   logic [PIXEL_W-1:0] in_src_ff;
   logic [PIXEL_W-1:0] in_dst_ff;
   logic [PIXEL_W-1:0] in_pat_ff;
   logic               out_valid_ff;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic               out_bad_ff;
   logic [PIXEL_W-1:0] alu_pixel;
   logic               alu_bad;
   logic               out_take;
   logic               in_take;

   rop_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rop_alu u_alu (
      .cfg       (cfg),
      .op        (in_op_ff),
      .src_pixel (in_src_ff),
      .dst_pixel (in_dst_ff),
      .pat_pixel (in_pat_ff),
      .new_pixel (alu_pixel),
      .bad_op    (alu_bad)
   );

   // The result register can load when it is empty or its word leaves this cycle.
   assign out_take  = ~out_valid_ff | rsp_ready;
   assign in_take   = ~in_valid_ff | out_take;
   assign req_ready = in_take;

   assign rsp_valid     = out_valid_ff;
   assign rsp_new_pixel = out_pixel_ff;
   assign rsp_bad_op    = out_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            in_valid_ff <= req_valid;
         end
         if (out_take) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_op_ff  <= req_op;
         in_src_ff <= req_src_pixel;
         in_dst_ff <= req_dst_pixel;
         in_pat_ff <= req_pat_pixel;
      end
      if (out_take) begin
         out_pixel_ff <= alu_pixel;
         out_bad_ff   <= alu_bad;
      end
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the raster-op pixel unit with its own pixel predictor.
module tb_top;
   import rop_pkg::*;

   localparam int WATCHDOG_LIMIT    = 1000;
   localparam int LONG_HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES      = 10;
   localparam int SETTLE_CYCLES     = 4;
   localparam int WORDS_PER_PHASE   = 220;
   localparam int PHASE_COUNT       = 6;
   localparam int UNMAPPED_REG      = 5;
   localparam int DIRECTED_ROWS     = 24;
   localparam logic [OP_W-1:0] FIRST_UNKNOWN_OP = 5'd19;
   localparam logic [OP_W-1:0] LAST_UNKNOWN_OP  = 5'd31;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               bad;
   } pixel_result_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [PIXEL_W-1:0] src;
      logic [PIXEL_W-1:0] dst;
      logic [PIXEL_W-1:0] pat;
      logic               fixed;
      logic [PIXEL_W-1:0] want_pixel;
      logic               want_bad;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op;
   logic [PIXEL_W-1:0]    req_src_pixel;
   logic [PIXEL_W-1:0]    req_dst_pixel;
   logic [PIXEL_W-1:0]    req_pat_pixel;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PIXEL_W-1:0]    rsp_new_pixel;
   logic                  rsp_bad_op;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type          shadow_cfg;
   pixel_result_type expected_pixels[$];
   int               mismatch_count = 0;
   int               sink_gap = 0;
   bit               long_hold = 1'b0;
   bit               no_idle = 1'b0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_BLACKNESS,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b0},
      '{OP_WHITENESS,   32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b0},
      '{OP_SRCCOPY,     32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b0},
      '{OP_SRCCOPY,     32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b0},
      '{OP_PATCOPY,     32'h00000000, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hFF000000, 1'b0},
      '{FIRST_UNKNOWN_OP, 32'hFFFFFFFF, 32'h12345678, 32'hFFFFFFFF, 1'b1, 32'h12345678, 1'b1},
      '{LAST_UNKNOWN_OP,  32'h00000000, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b1},
      '{OP_DSTINVERT,   32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b0},
      '{OP_SPNA,        32'hF0F0F0F0, 32'h0F0F0F0F, 32'hFF00FF00, 1'b0, '0, 1'b0},
      '{OP_DSNA,        32'hF0F0F0F0, 32'hFFFF0000, 32'h00000000, 1'b0, '0, 1'b0},
      '{OP_DSPDXAX,     32'h000000FF, 32'hA5A5A5A5, 32'h00000000, 1'b0, '0, 1'b0},
      '{OP_DSPDXAX,     32'hFFFFFF00, 32'h5A5A5A5A, 32'hFFFFFFFF, 1'b0, '0, 1'b0},
      '{OP_NOTSRCCOPY,  32'h0000FFFF, 32'h12345678, 32'h00000000, 1'b0, '0, 1'b0},
      '{OP_SRCERASE,    32'hFFFF0000, 32'hFF00FF00, 32'h00000000, 1'b0, '0, 1'b0},
      '{OP_NOTSRCERASE, 32'hFFFF0000, 32'hFF00FF00, 32'hFFFFFFFF, 1'b0, '0, 1'b0},
      '{OP_SRCINVERT,   32'hAAAAAAAA, 32'hFFFF0000, 32'h00000000, 1'b0, '0, 1'b0},
      '{OP_SRCAND,      32'hAAAAAAAA, 32'h0F0F0F0F, 32'h00000000, 1'b0, '0, 1'b0},
      '{OP_SRCPAINT,    32'hAAAAAAAA, 32'h55550000, 32'h00000000, 1'b0, '0, 1'b0},
      '{OP_MERGECOPY,   32'hFFFFFFFF, 32'h00000000, 32'h3C3C3C3C, 1'b0, '0, 1'b0},
      '{OP_MERGEPAINT,  32'h0000FFFF, 32'h00FF0000, 32'hFFFFFFFF, 1'b0, '0, 1'b0},
      '{OP_PATINVERT,   32'h00000000, 32'h87654321, 32'hFFFFFFFF, 1'b0, '0, 1'b0},
      '{OP_PATPAINT,    32'hFFFF0000, 32'h00000F00, 32'h000000F0, 1'b0, '0, 1'b0},
      '{OP_PDXN,        32'h00000000, 32'hFF00FF00, 32'hF0F0F0F0, 1'b0, '0, 1'b0},
      '{OP_DSPDXAX,     32'h0000003C, 32'hFFFFFFFF, 32'h00000000, 1'b0, '0, 1'b0}
   };

   raster_op_pixel_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_src_pixel (req_src_pixel),
      .req_dst_pixel (req_dst_pixel),
      .req_pat_pixel (req_pat_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_new_pixel (rsp_new_pixel),
      .rsp_bad_op    (rsp_bad_op),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #4 clock = ~clock;

   // A 0x00BBGGRR colour becomes an opaque ARGB word, or ABGR when the order is inverted.
   function automatic logic [PIXEL_W-1:0] pack_bgr(input logic [COLOR_W-1:0] bgr,
                                                   input logic invert);
      if (invert) begin
         return {OPAQUE_ALPHA, bgr};
      end
      return {OPAQUE_ALPHA, bgr[7:0], bgr[15:8], bgr[23:16]};
   endfunction

   function automatic pixel_result_type predict_pixel(input logic [OP_W-1:0] op,
                                                      input logic [PIXEL_W-1:0] s,
                                                      input logic [PIXEL_W-1:0] d,
                                                      input logic [PIXEL_W-1:0] p);
      logic [PIXEL_W-1:0] brush;
      logic [PIXEL_W-1:0] text_word;
      logic [COLOR_W-1:0] mask;
      pixel_result_type   res;
      brush = shadow_cfg.brush_solid ?
              pack_bgr(shadow_cfg.brush_color, shadow_cfg.invert_order) : p;
      text_word = pack_bgr(shadow_cfg.text_color, shadow_cfg.invert_order);
      mask = {3{s[7:0]}};
      res.bad = 1'b0;
      case (op)
         OP_BLACKNESS:   res.pixel = shadow_cfg.alpha_black ? {OPAQUE_ALPHA, 24'h0} : '0;
         OP_WHITENESS:   res.pixel = '1;
         OP_SRCCOPY:     res.pixel = s;
         OP_SPNA:        res.pixel = s & ~p;
         OP_DSNA:        res.pixel = ~s & d;
         // The glyph blend touches only the color lanes; alpha comes from the destination.
         OP_DSPDXAX:     res.pixel = {d[31:24], (mask & text_word[23:0]) | (~mask & d[23:0])};
         OP_NOTSRCCOPY:  res.pixel = ~s;
         OP_DSTINVERT:   res.pixel = ~d;
         OP_SRCERASE:    res.pixel = s & ~d;
         OP_NOTSRCERASE: res.pixel = ~s & ~d;
         OP_SRCINVERT:   res.pixel = d ^ s;
         OP_SRCAND:      res.pixel = d & s;
         OP_SRCPAINT:    res.pixel = d | s;
         OP_MERGECOPY:   res.pixel = s & p;
         OP_MERGEPAINT:  res.pixel = ~s | d;
         OP_PATCOPY:     res.pixel = brush;
         OP_PATINVERT:   res.pixel = d ^ brush;
         OP_PATPAINT:    res.pixel = d | p | ~s;
         OP_PDXN:        res.pixel = d ^ ~p;
         default: begin
            res.pixel = d;
            res.bad = 1'b1;
         end
      endcase
      return res;
   endfunction

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_W-1:0] rand_op();
      if ($urandom_range(0, 9) == 0) begin
         return OP_W'($urandom_range(FIRST_UNKNOWN_OP, LAST_UNKNOWN_OP));
      end
      return OP_W'($urandom_range(OP_BLACKNESS, OP_PDXN));
   endfunction

   task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                  input logic [PIXEL_W-1:0] want);
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic csr_write(input int index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(index * 4);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_INVERT_ORDER: shadow_cfg.invert_order = value[0];
         REG_ALPHA_BLACK:  shadow_cfg.alpha_black = value[0];
         REG_BRUSH_SOLID:  shadow_cfg.brush_solid = value[0];
         REG_BRUSH_COLOR:  shadow_cfg.brush_color = value[COLOR_W-1:0];
         REG_TEXT_COLOR:   shadow_cfg.text_color = value[COLOR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] invert,
                                 input logic [CSR_DATA_W-1:0] alpha,
                                 input logic [CSR_DATA_W-1:0] solid,
                                 input logic [CSR_DATA_W-1:0] brush,
                                 input logic [CSR_DATA_W-1:0] text);
      csr_write(REG_INVERT_ORDER, invert);
      csr_write(REG_ALPHA_BLACK, alpha);
      csr_write(REG_BRUSH_SOLID, solid);
      csr_write(REG_BRUSH_COLOR, brush);
      csr_write(REG_TEXT_COLOR, text);
   endtask

   task automatic push_word(input logic [OP_W-1:0] op, input logic [PIXEL_W-1:0] s,
                            input logic [PIXEL_W-1:0] d, input logic [PIXEL_W-1:0] p,
                            input logic fixed, input logic [PIXEL_W-1:0] want_pixel,
                            input logic want_bad);
      int               gap;
      pixel_result_type want;
      gap = idle_draw();
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_src_pixel <= s;
      req_dst_pixel <= d;
      req_pat_pixel <= p;
      do @(posedge clock); while (!req_ready);
      want = fixed ? pixel_result_type'({want_pixel, want_bad}) : predict_pixel(op, s, d, p);
      expected_pixels.push_back(want);
   endtask

   // Every word yields a result, so an empty queue means the pipeline is empty.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always begin
      @(negedge clock);
      if (long_hold) begin
         rsp_ready <= 1'b0;
         repeat (LONG_HOLD_CYCLES) @(negedge clock);
         long_hold = 1'b0;
         rsp_ready <= 1'b1;
      end else if (sink_gap != 0) begin
         rsp_ready <= 1'b0;
         sink_gap--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected word", rsp_new_pixel, '0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_new_pixel !== want.pixel) begin
               report_mismatch("new_pixel", rsp_new_pixel, want.pixel);
            end
            if (rsp_bad_op !== want.bad) begin
               report_mismatch("bad_op", PIXEL_W'(rsp_bad_op), PIXEL_W'(want.bad));
            end
         end
         sink_gap = idle_draw();
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
            stalled = 0;
         end else begin
            stalled++;
         end
         if (stalled >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      req_valid = 1'b0;
      req_op = '0;
      req_src_pixel = '0;
      req_dst_pixel = '0;
      req_pat_pixel = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      shadow_cfg = '{invert_order: 1'b0, alpha_black: 1'b0, brush_solid: 1'b1,
                     brush_color: '0, text_color: '0};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // The directed words run under the reset settings.
      foreach (directed_rows[i]) begin
         push_word(directed_rows[i].op, directed_rows[i].src, directed_rows[i].dst,
                   directed_rows[i].pat, directed_rows[i].fixed,
                   directed_rows[i].want_pixel, directed_rows[i].want_bad);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         case (phase)
            0: apply_settings(0, 1, 1, $urandom(), $urandom());
            1: begin
               apply_settings(1, 1, 1, 24'hFFFFFF, 24'hFFFFFF);
               long_hold = 1'b1;
            end
            2: apply_settings(1, 0, 0, 0, $urandom());
            3: begin
               // Upper bits must be dropped and a write past the last register ignored.
               apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
               csr_write(UNMAPPED_REG, $urandom());
               no_idle = 1'b1;
            end
            4: begin
               apply_settings(0, 0, 1, $urandom(), 0);
               no_idle = 1'b0;
            end
            default: apply_settings($urandom(), $urandom(), $urandom(), $urandom(),
                                    $urandom());
         endcase
         repeat (WORDS_PER_PHASE) begin
            push_word(rand_op(), rand_pixel(), rand_pixel(), rand_pixel(), 1'b0, '0, 1'b0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
